// ===== src/huffman_code_bit_packer_unit_assert.svh =====
// Assertion macros for the Huffman code bit packer.
// Included by the checker; needs nothing else.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hcbp_pkg.sv =====
// Shared types and constants of the Huffman code bit packer.
// No dependencies.
package hcbp_pkg;

  localparam int unsigned SymbolCountDef = 256;
  localparam int unsigned MaxCodeLen     = 32;
  localparam int unsigned QueueDepth     = 4;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned LenW    = 6;
  localparam int unsigned WinW    = CodeW + ByteW;  // up to 7 held bits + 32 code bits
  localparam int unsigned LenCapI = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  localparam logic [LenW-1:0] LenCap = LenW'(LenCapI);

  localparam logic [1:0] ModeLoad   = 2'd0;
  localparam logic [1:0] ModeEncode = 2'd1;
  localparam logic [1:0] ModeFlush  = 2'd2;

  typedef enum logic [1:0] {
    OpEncode,
    OpMissing,
    OpFlush
  } op_kind_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       symbol;
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic [3:0]  valid_bits;
    logic [31:0] total_bytes;
    logic        status;
    logic        last;
  } res_t;

  typedef struct packed {
    op_kind_e         kind;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } op_t;

endpackage

// ===== src/huffman_code_bit_packer_unit.sv =====
// Path: an encode beat passes table read, queue, window update and result register;
// further bytes follow one per cycle; flush and missing-code beats skip the window
// update. Throughput: one beat per cycle while busy is low, into a 4-entry queue; the
// packer drains an operation only while no full byte waits in the window, so busy
// rises on long codes. Reset: async active low clears code-present bits, window, fill,
// byte total. Results carry a one-cycle strobe; no receiver stall.
module huffman_code_bit_packer_unit #(
  parameter int unsigned SymbolCount = hcbp_pkg::SymbolCountDef,
  parameter int unsigned QDepth      = hcbp_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  hcbp_pkg::in_t  in_i,
  output logic           strobe_o,
  output hcbp_pkg::res_t res_o
);
  import hcbp_pkg::*;

  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic            accept;
  logic            push;
  op_t             op_front, op_back;
  logic            pop, empty;
  logic [CntW-1:0] q_count;

  // A beat is taken whenever start meets a free slot. The front stage may
  // hold one operation in flight, so it is counted against the queue space.
  assign accept = start && !busy;
  assign busy   = (({1'b0, q_count} + (CntW + 1)'(push)) >= (CntW + 1)'(QDepth));

  // Front: code table lookup and operation classification.
  hcbp_front #(
    .SymbolCount(SymbolCount)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_i),
    .push_o  (push),
    .op_o    (op_front)
  );

  // Queue decouples table lookup from byte draining.
  hcbp_fifo #(
    .Depth(QDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op_front),
    .pop_i  (pop),
    .op_o   (op_back),
    .empty_o(empty),
    .count_o(q_count)
  );

  // Back: packs code bits MSB first and emits a beat per finished byte and per flush or missing-code operation.
  hcbp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .op_i    (op_back),
    .pop_o   (pop),
    .strobe_o(strobe_o),
    .res_o   (res_o)
  );

endmodule

// ===== src/hcbp_fifo.sv =====
// Short operation queue between front and back of the bit packer.
// Depends on hcbp_pkg.
module hcbp_fifo #(
  parameter int unsigned Depth = hcbp_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  hcbp_pkg::op_t              op_i,
  input  logic                       pop_i,
  output hcbp_pkg::op_t              op_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import hcbp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign op_o    = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ===== src/hcbp_front.sv =====
// Front end: takes input beats, owns the code table, classifies operations.
// Depends on hcbp_pkg.
module hcbp_front #(
  parameter int unsigned SymbolCount = hcbp_pkg::SymbolCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  hcbp_pkg::in_t in_i,
  output logic          push_o,
  output hcbp_pkg::op_t op_o
);
  import hcbp_pkg::*;

  localparam int unsigned IdxW = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;
  localparam int unsigned EntW = CodeW + LenW;

  logic [EntW-1:0]        table_mem [SymbolCount];
  logic [EntW-1:0]        rd_q;
  logic [SymbolCount-1:0] present_q;
  logic                   valid_q;
  op_kind_e               kind_q;

  logic                   in_table;
  logic [IdxW-1:0]        idx;
  logic [LenW-1:0]        len_sat;
  logic                   is_load, is_encode, is_flush, hit;

  always_comb begin
    in_table  = ({1'b0, in_i.symbol} < 9'(SymbolCount));
    idx       = in_i.symbol[IdxW-1:0];
    len_sat   = (in_i.code_length > LenCap) ? LenCap : in_i.code_length;
    is_load   = accept_i && (in_i.mode == ModeLoad);
    is_encode = accept_i && (in_i.mode == ModeEncode);
    is_flush  = accept_i && (in_i.mode == ModeFlush);
    hit       = in_table ? present_q[idx] : 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (is_load && in_table) begin
      table_mem[idx] <= {in_i.code_bits, len_sat};
    end
    if (is_encode && in_table) begin
      rd_q <= table_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      valid_q   <= 1'b0;
      kind_q    <= OpFlush;
    end else begin
      if (is_load && in_table) begin
        present_q[idx] <= 1'b1;
      end
      valid_q <= is_encode || is_flush;
      if (is_encode) begin
        kind_q <= hit ? OpEncode : OpMissing;
      end else if (is_flush) begin
        kind_q <= OpFlush;
      end
    end
  end

  assign push_o    = valid_q;
  assign op_o.kind = kind_q;
  assign op_o.code = rd_q[EntW-1:LenW];
  assign op_o.len  = rd_q[LenW-1:0];

endmodule

// ===== src/hcbp_back.sv =====
// Back end: bit window, byte emission, byte total and result register.
// Depends on hcbp_pkg.
module hcbp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  hcbp_pkg::op_t  op_i,
  output logic           pop_o,
  output logic           strobe_o,
  output hcbp_pkg::res_t res_o
);
  import hcbp_pkg::*;

  logic [WinW-1:0] win_q, win_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [31:0]     total_q, total_d;
  logic            strobe_q, strobe_d;
  res_t            res_q, res_d;
  logic [WinW-1:0] aligned;
  logic [LenW-1:0] sh;
  logic            full;

  always_comb begin
    full    = (cnt_q >= LenW'(ByteW));
    sh      = LenW'(CodeW) - op_i.len;
    aligned = {op_i.code, ByteW'(0)} << sh;
    pop_o   = !empty_i && !full;

    win_d    = win_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    strobe_d = 1'b0;
    res_d    = res_q;

    if (full) begin
      // one full byte leaves the top of the window each cycle
      win_d    = win_q << ByteW;
      cnt_d    = cnt_q - LenW'(ByteW);
      total_d  = total_q + 1'b1;
      strobe_d = 1'b1;
      res_d.out_byte    = win_q[WinW-1 -: ByteW];
      res_d.has_byte    = 1'b1;
      res_d.valid_bits  = 4'd8;
      res_d.total_bytes = total_q + 1'b1;
      res_d.status      = 1'b0;
      res_d.last        = (cnt_q < LenW'(2 * ByteW));
    end else if (!empty_i) begin
      unique case (op_i.kind)
        OpEncode: begin
          win_d = win_q | (aligned >> cnt_q[2:0]);
          cnt_d = cnt_q + op_i.len;
        end
        OpMissing: begin
          strobe_d          = 1'b1;
          res_d.out_byte    = '0;
          res_d.has_byte    = 1'b0;
          res_d.valid_bits  = '0;
          res_d.total_bytes = total_q;
          res_d.status      = 1'b1;
          res_d.last        = 1'b1;
        end
        OpFlush: begin
          strobe_d     = 1'b1;
          res_d.status = 1'b0;
          res_d.last   = 1'b1;
          if (cnt_q != '0) begin
            res_d.out_byte    = win_q[WinW-1 -: ByteW];
            res_d.has_byte    = 1'b1;
            res_d.valid_bits  = {1'b0, cnt_q[2:0]};
            res_d.total_bytes = total_q + 1'b1;
          end else begin
            res_d.out_byte    = '0;
            res_d.has_byte    = 1'b0;
            res_d.valid_bits  = '0;
            res_d.total_bytes = total_q;
          end
          win_d   = '0;
          cnt_d   = '0;
          total_d = '0;
        end
        default: begin
          strobe_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      cnt_q    <= '0;
      total_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      win_q    <= win_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

// ===== src/hcbp_checker.sv =====
// Port-level checks for the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer_unit_assert.svh.
`include "huffman_code_bit_packer_unit_assert.svh"

module hcbp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           strobe_o,
  input hcbp_pkg::res_t res_o
);
  import hcbp_pkg::*;

  logic mid_byte;

  assign mid_byte = strobe_o && res_o.has_byte && !res_o.last;

  `HCBP_ASSERT_IMP(a_empty_beat, clk_i, rst_ni, strobe_o && !res_o.has_byte,
    (res_o.valid_bits == 4'd0) && (res_o.out_byte == 8'd0), "empty beat carries data")
  `HCBP_ASSERT_IMP(a_missing, clk_i, rst_ni, strobe_o && res_o.status,
    res_o.last && !res_o.has_byte, "missing-code beat is not a lone empty beat")
  `HCBP_ASSERT_IMP(a_mid_full, clk_i, rst_ni, mid_byte,
    (res_o.valid_bits == 4'd8) && !res_o.status, "non-final byte is not full")
  `HCBP_ASSERT_NXT(a_burst, clk_i, rst_ni, mid_byte,
    strobe_o && res_o.has_byte && (res_o.total_bytes == $past(res_o.total_bytes) + 32'd1),
    "byte burst broken or total not counting")

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (.*);
